// ----- rtl/gbpi_pkg.sv -----
// Shared types and constants for the GPIO bank with pin interrupts.
// Depends on nothing; every other file of the block imports it.
package gbpi_pkg;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 6;
  localparam int CMD_W       = 2;
  localparam int CFG_W       = 8;
  localparam int TRIG_W      = 3;
  localparam int PIN_COUNT_DEF = 32;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [CFG_W-1:0]  pin_cfg_t;
  typedef logic [TRIG_W-1:0] trig_t;

  // Transaction commands
  localparam cmd_t CMD_READ   = 2'd0;
  localparam cmd_t CMD_WRITE  = 2'd1;
  localparam cmd_t CMD_SAMPLE = 2'd2;

  // Register word map above the per-pin config words
  localparam addr_t WORD_STATUS = 6'd32;
  localparam addr_t WORD_INPUT  = 6'd33;
  localparam addr_t WORD_OUTPUT = 6'd34;

  // Config byte fields
  localparam int CFG_OUT_BUF_BIT = 2;
  localparam int CFG_INT_EN_BIT  = 3;
  localparam int CFG_TRIG_LSB    = 5;

  // Trigger codes; the rest mean no trigger
  localparam trig_t TRIG_HIGH = 3'd0;
  localparam trig_t TRIG_LOW  = 3'd1;
  localparam trig_t TRIG_RISE = 3'd2;
  localparam trig_t TRIG_FALL = 3'd3;
  localparam trig_t TRIG_BOTH = 3'd4;

endpackage

// ----- rtl/gbpi_ifs.sv -----
// Valid/ready channel interfaces for the GPIO bank: command in, result out.
// Depends on gbpi_pkg.
interface gbpi_in_if
  import gbpi_pkg::*;
();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  addr_t addr_word;
  data_t write_data;
  data_t pin_levels;

  modport source (output valid, output cmd, output addr_word, output write_data,
                  output pin_levels, input ready);
  modport sink   (input valid, input cmd, input addr_word, input write_data,
                  input pin_levels, output ready);
endinterface

interface gbpi_out_if
  import gbpi_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t read_data;
  data_t pad_drive;
  data_t pad_enable;
  data_t irq_pending;
  logic  bad_address;

  modport source (output valid, output read_data, output pad_drive, output pad_enable,
                  output irq_pending, output bad_address, input ready);
  modport sink   (input valid, input read_data, input pad_drive, input pad_enable,
                  input irq_pending, input bad_address, output ready);
endinterface

// ----- rtl/gpio_bank_with_pin_interrupts.sv -----
// GPIO bank with per-pin interrupts behind a word-addressed register map.
// An accepted transaction reaches its result through the input register, then the
// result register. Throughput: one transaction per cycle while out_ch is not stalled.
// Reset (rst_n low, synchronous): clears pin configs, output register, interrupt
// status, sampled pins and both stage valids. No clearing pass is needed.
// Depends on gbpi_pkg, gbpi_ifs (channels) and gbpi_trigger.
module gpio_bank_with_pin_interrupts
  import gbpi_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gbpi_in_if.sink      in_ch,
  gbpi_out_if.source   out_ch
);

  localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam logic [2*DATA_W-1:0] MASK_WIDE = ((2*DATA_W)'(1) << PIN_COUNT) - (2*DATA_W)'(1);
  localparam data_t PIN_MASK = MASK_WIDE[DATA_W-1:0];
  localparam addr_t CFG_WORDS = ADDR_W'(PIN_COUNT);

  // Input register stage
  logic  s1_valid_r;
  cmd_t  s1_cmd_r;
  addr_t s1_addr_r;
  data_t s1_wdata_r;
  data_t s1_levels_r;

  // Architectural state
  pin_cfg_t [PIN_COUNT-1:0] cfg_r, cfg_nxt;
  logic [PIN_COUNT-1:0] out_bits_r, out_bits_nxt;
  logic [PIN_COUNT-1:0] status_r, status_nxt;
  logic [PIN_COUNT-1:0] sampled_r, sampled_nxt;

  // Result register
  logic  out_valid_r;
  data_t rdata_r, rdata_nxt;
  data_t drive_r;
  data_t enable_r, enable_nxt;
  data_t pending_r;
  logic  bad_r, bad_nxt;

  logic out_free;
  logic s1_adv;
  logic is_cfg, is_used, is_bus;
  logic [PIN_COUNT-1:0] now_levels;
  logic [PIN_COUNT-1:0] hit;

  // The result register frees up when empty or being taken; stage 1 advances
  // into it then, and can refill in the same cycle.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_addr_r   <= in_ch.addr_word;
      s1_wdata_r  <= in_ch.write_data;
      s1_levels_r <= in_ch.pin_levels;
    end
  end

  // Decode the held transaction
  assign is_bus     = (s1_cmd_r == CMD_READ) || (s1_cmd_r == CMD_WRITE);
  assign is_cfg     = s1_addr_r < CFG_WORDS;
  assign is_used    = is_cfg || (s1_addr_r == WORD_STATUS) || (s1_addr_r == WORD_INPUT)
                      || (s1_addr_r == WORD_OUTPUT);
  assign now_levels = s1_levels_r[PIN_COUNT-1:0];

  gbpi_trigger #(
    .PIN_COUNT (PIN_COUNT)
  ) u_trigger (
    .cfg        (cfg_r),
    .cur_levels (now_levels),
    .old_levels (sampled_r),
    .hit        (hit)
  );

  // Next state: one write or one sample per transaction
  always_comb begin
    cfg_nxt      = cfg_r;
    out_bits_nxt = out_bits_r;
    status_nxt   = status_r;
    sampled_nxt  = sampled_r;
    if (s1_cmd_r == CMD_WRITE && is_used) begin
      priority if (is_cfg) begin
        cfg_nxt[s1_addr_r[IDX_W-1:0]] = s1_wdata_r[CFG_W-1:0];
      end else if (s1_addr_r == WORD_STATUS) begin
        // Write one to clear
        status_nxt = status_r & ~s1_wdata_r[PIN_COUNT-1:0];
      end else if (s1_addr_r == WORD_OUTPUT) begin
        out_bits_nxt = s1_wdata_r[PIN_COUNT-1:0];
      end else begin
        // Input word is read only: drop the write
        out_bits_nxt = out_bits_r;
      end
    end else if (s1_cmd_r == CMD_SAMPLE) begin
      status_nxt  = status_r | hit;
      sampled_nxt = now_levels;
    end
  end

  // Read mux and result fields, all showing post-transaction state
  always_comb begin
    rdata_nxt = '0;
    if (s1_cmd_r == CMD_READ && is_used) begin
      priority if (is_cfg) begin
        rdata_nxt = DATA_W'(cfg_r[s1_addr_r[IDX_W-1:0]]);
      end else if (s1_addr_r == WORD_STATUS) begin
        rdata_nxt = DATA_W'(status_r);
      end else if (s1_addr_r == WORD_INPUT) begin
        rdata_nxt = DATA_W'(sampled_r);
      end else begin
        rdata_nxt = DATA_W'(out_bits_r);
      end
    end
    bad_nxt = is_bus && !is_used;
    enable_nxt = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      enable_nxt[i] = cfg_nxt[i][CFG_OUT_BUF_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= '0;
      out_bits_r <= '0;
      status_r   <= '0;
      sampled_r  <= '0;
    end else if (s1_adv) begin
      cfg_r      <= cfg_nxt;
      out_bits_r <= out_bits_nxt;
      status_r   <= status_nxt;
      sampled_r  <= sampled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rdata_r   <= rdata_nxt;
      drive_r   <= DATA_W'(out_bits_nxt);
      enable_r  <= enable_nxt;
      pending_r <= DATA_W'(status_nxt);
      bad_r     <= bad_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = rdata_r;
  assign out_ch.pad_drive   = drive_r;
  assign out_ch.pad_enable  = enable_r;
  assign out_ch.irq_pending = pending_r;
  assign out_ch.bad_address = bad_r;

`ifndef SYNTHESIS
  // Status bits only rise on a pin sample
  a_status_rise_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r != CMD_SAMPLE) |=> ((status_r & ~$past(status_r)) == '0))
    else $error("interrupt status set without a sample");

  // A stalled result holds stage 1 in place
  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(s1_cmd_r)))
    else $error("stage 1 moved while result stalled");

  // A flagged access returns no data
  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (rdata_r == '0))
    else $error("bad address with nonzero read data");

  // Nothing appears on pins outside the bank
  a_pins_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (((drive_r | enable_r | pending_r) & ~PIN_MASK) == '0))
    else $error("activity on pins beyond the bank");
`endif

endmodule

// ----- rtl/gbpi_trigger.sv -----
// Per-pin interrupt trigger evaluation for one pin sample.
// Depends on gbpi_pkg.
module gbpi_trigger
  import gbpi_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF
) (
  input  pin_cfg_t [PIN_COUNT-1:0] cfg,
  input  logic     [PIN_COUNT-1:0] cur_levels,
  input  logic     [PIN_COUNT-1:0] old_levels,
  output logic     [PIN_COUNT-1:0] hit
);

  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      hit[i] = 1'b0;
      if (cfg[i][CFG_INT_EN_BIT]) begin
        unique case (cfg[i][CFG_TRIG_LSB +: TRIG_W])
          TRIG_HIGH: hit[i] = cur_levels[i];
          TRIG_LOW:  hit[i] = !cur_levels[i];
          TRIG_RISE: hit[i] = cur_levels[i] && !old_levels[i];
          TRIG_FALL: hit[i] = !cur_levels[i] && old_levels[i];
          TRIG_BOTH: hit[i] = cur_levels[i] != old_levels[i];
          default:   hit[i] = 1'b0;
        endcase
      end
    end
  end

endmodule
